### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define BSOC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define BSOC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bsoc_pkg.sv
package bsoc_pkg;

	localparam int unsigned RAW_W   = 24;
	localparam int unsigned CAL_W   = 16;
	localparam int unsigned RES_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CAL_NUM = 6;
	localparam int unsigned DT_W    = 25;
	localparam int unsigned TEMP_W  = 20;
	localparam int unsigned TI_W    = 18;
	localparam int unsigned STORE_W = 40;
	localparam int unsigned MOP_W   = 26;
	localparam int unsigned PROD_W  = 2 * MOP_W;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned PC_W    = 4;

	// calibration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

	localparam logic KIND_TEMP = 1'b0;
	localparam logic KIND_PRES = 1'b1;

	localparam logic signed [TEMP_W-1:0] TEMP_REF   = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] VLOW_LIMIT = -20'sd1500;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_DT_C6,
		MUL_C3_DT,
		MUL_C4_DT,
		MUL_DT_DT,
		MUL_D_D,
		MUL_E_E,
		MUL_RAW_SLO,
		MUL_RAW_SHI
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_DT,
		OP_TEMP,
		OP_SENS,
		OP_OFF,
		OP_TI,
		OP_BAND,
		OP_VLOW,
		OP_STORE_T,
		OP_ACC_LO,
		OP_ACC_HI,
		OP_DIV21,
		OP_SUB_OFF,
		OP_EMIT_P
	} dp_op_t;

	typedef struct packed {
		logic     load;
		logic     go;
		mul_sel_t mul;
		dp_op_t   op;
	} dp_ctl_t;

	typedef struct packed {
		logic vlow;
		logic out_blocked;
	} dp_stat_t;

endpackage

### sv/bsoc_if.sv
interface bsoc_in_if;
	logic                         valid;
	logic                         ready;
	logic [bsoc_pkg::RAW_W-1:0]   raw_conversion;

	modport source (output valid, output raw_conversion, input ready);
	modport sink (input valid, input raw_conversion, output ready);
endinterface

interface bsoc_out_if;
	logic                               valid;
	logic                               ready;
	logic                               result_kind;
	logic signed [bsoc_pkg::RES_W-1:0]  result_value;

	modport source (output valid, output result_kind, output result_value, input ready);
	modport sink (input valid, input result_kind, input result_value, output ready);
endinterface

interface bsoc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bsoc_pkg::CFG_IDX_W-1:0]   index;
	logic [bsoc_pkg::CAL_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/bsoc_seq.sv
module bsoc_seq #(
	parameter int unsigned PRESSURE_PER_TEMP = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bsoc_pkg::dp_stat_t stat,
	output logic               ready,
	output bsoc_pkg::dp_ctl_t  ctl
);
	import bsoc_pkg::*;

	localparam int unsigned PHASE_W = $clog2(PRESSURE_PER_TEMP + 1);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PRESSURE_PER_TEMP);
	localparam logic [PHASE_W-1:0] PHASE_TEMP = '0;

	localparam logic [PC_W-1:0] PC_TEMP    = 4'd0;
	localparam logic [PC_W-1:0] PC_T_STORE = 4'd8;
	localparam logic [PC_W-1:0] PC_PRES    = 4'd9;

	typedef struct packed {
		mul_sel_t        mul;
		dp_op_t          op;
		logic            jmp_nvlow;
		logic [PC_W-1:0] target;
		logic            emit;
		logic            last;
	} uword_t;

	function automatic uword_t mk(mul_sel_t m, dp_op_t o, logic j, logic [PC_W-1:0] t,
			logic em, logic la);
		uword_t w;
		w.mul       = m;
		w.op        = o;
		w.jmp_nvlow = j;
		w.target    = t;
		w.emit      = em;
		w.last      = la;
		return w;
	endfunction

	// control store: temperature program, then pressure program
	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			4'd0:    w = mk(MUL_NONE,    OP_LOAD_DT, 1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd1:    w = mk(MUL_DT_C6,   OP_NOP,     1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd2:    w = mk(MUL_C3_DT,   OP_TEMP,    1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd3:    w = mk(MUL_C4_DT,   OP_SENS,    1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd4:    w = mk(MUL_DT_DT,   OP_OFF,     1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd5:    w = mk(MUL_D_D,     OP_TI,      1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd6:    w = mk(MUL_E_E,     OP_BAND,    1'b1, PC_T_STORE, 1'b0, 1'b0);
			4'd7:    w = mk(MUL_NONE,    OP_VLOW,    1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd8:    w = mk(MUL_NONE,    OP_STORE_T, 1'b0, PC_TEMP,    1'b1, 1'b1);
			4'd9:    w = mk(MUL_RAW_SLO, OP_NOP,     1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd10:   w = mk(MUL_RAW_SHI, OP_ACC_LO,  1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd11:   w = mk(MUL_NONE,    OP_ACC_HI,  1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd12:   w = mk(MUL_NONE,    OP_DIV21,   1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd13:   w = mk(MUL_NONE,    OP_SUB_OFF, 1'b0, PC_TEMP,    1'b0, 1'b0);
			4'd14:   w = mk(MUL_NONE,    OP_EMIT_P,  1'b0, PC_TEMP,    1'b1, 1'b1);
			default: w = mk(MUL_NONE,    OP_NOP,     1'b0, PC_TEMP,    1'b0, 1'b1);
		endcase
		return w;
	endfunction

	logic               busy_q;
	logic [PC_W-1:0]    pc_q;
	logic [PHASE_W-1:0] phase_q;
	uword_t             uw;
	logic               stall;
	logic               go;

	assign uw    = ucode(pc_q);
	// an emitting step waits while the output register is full and not being taken
	assign stall = uw.emit & stat.out_blocked;
	assign go    = busy_q & ~stall;
	assign ready = ~busy_q;

	assign ctl.load = start;
	assign ctl.go   = go;
	assign ctl.mul  = uw.mul;
	assign ctl.op   = uw.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pc_q    <= PC_TEMP;
			phase_q <= PHASE_TEMP;
		end else begin
			if (start) begin
				busy_q  <= 1'b1;
				pc_q    <= (phase_q == PHASE_TEMP) ? PC_TEMP : PC_PRES;
				phase_q <= (phase_q == PHASE_LAST) ? PHASE_TEMP : phase_q + 1'b1;
			end else if (go) begin
				if (uw.last) begin
					busy_q <= 1'b0;
				end else if (uw.jmp_nvlow && !stat.vlow) begin
					pc_q <= uw.target;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

endmodule

### sv/bsoc_dp.sv
module bsoc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bsoc_pkg::dp_ctl_t                  ctl,
	input  logic [bsoc_pkg::RAW_W-1:0]         raw,
	input  logic                               cfg_valid,
	input  logic [bsoc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsoc_pkg::CAL_W-1:0]         cfg_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic                               out_kind,
	output logic signed [bsoc_pkg::RES_W-1:0]  out_value,
	output bsoc_pkg::dp_stat_t                 stat
);
	import bsoc_pkg::*;

	// signed division by 2^k, truncating toward zero
	function automatic logic signed [ACC_W-1:0] sdiv_pow2(logic signed [ACC_W-1:0] x,
			int unsigned k);
		logic signed [ACC_W-1:0] bias;
		bias = x[ACC_W-1] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

	function automatic logic signed [RES_W-1:0] sat32(logic signed [ACC_W-1:0] x);
		logic signed [RES_W-1:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = x[RES_W-1:0];
		end
		return r;
	endfunction

	logic [CAL_W-1:0]               cal_q [CAL_NUM];
	logic [RAW_W-1:0]               raw_q;
	logic signed [DT_W-1:0]         dt_q;
	logic signed [TEMP_W-1:0]       temp_q;
	logic [TI_W-1:0]                ti_q;
	logic signed [STORE_W-1:0]      sens_q;
	logic signed [STORE_W-1:0]      off_q;
	logic signed [STORE_W-1:0]      stored_sens_q;
	logic signed [STORE_W-1:0]      stored_off_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic                           out_valid_q;
	logic                           out_kind_q;
	logic signed [RES_W-1:0]        out_value_q;

	logic signed [MOP_W-1:0]        ma;
	logic signed [MOP_W-1:0]        mb;
	logic signed [TEMP_W-1:0]       d;
	logic signed [TEMP_W-1:0]       e;
	logic signed [ACC_W-1:0]        wide;
	logic signed [ACC_W-1:0]        temp_full;
	logic signed [ACC_W-1:0]        sens_full;
	logic signed [ACC_W-1:0]        off_full;
	logic signed [ACC_W-1:0]        ti_full;
	logic signed [ACC_W-1:0]        offi;
	logic signed [ACC_W-1:0]        sensi;
	logic signed [ACC_W-1:0]        offv;
	logic signed [ACC_W-1:0]        sensv;
	logic signed [ACC_W-1:0]        temp_out;
	logic                           low_band;

	assign d        = temp_q - TEMP_REF;
	assign e        = temp_q - VLOW_LIMIT;
	assign low_band = temp_q < TEMP_REF;
	assign wide     = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (ctl.mul)
			MUL_DT_C6: begin
				ma = MOP_W'(dt_q);
				mb = $signed({{(MOP_W-CAL_W){1'b0}}, cal_q[REG_C6]});
			end
			MUL_C3_DT: begin
				ma = $signed({{(MOP_W-CAL_W){1'b0}}, cal_q[REG_C3]});
				mb = MOP_W'(dt_q);
			end
			MUL_C4_DT: begin
				ma = $signed({{(MOP_W-CAL_W){1'b0}}, cal_q[REG_C4]});
				mb = MOP_W'(dt_q);
			end
			MUL_DT_DT: begin
				ma = MOP_W'(dt_q);
				mb = MOP_W'(dt_q);
			end
			MUL_D_D: begin
				ma = MOP_W'(d);
				mb = MOP_W'(d);
			end
			MUL_E_E: begin
				ma = MOP_W'(e);
				mb = MOP_W'(e);
			end
			MUL_RAW_SLO: begin
				ma = $signed({{(MOP_W-RAW_W){1'b0}}, raw_q});
				mb = $signed({{(MOP_W-20){1'b0}}, stored_sens_q[19:0]});
			end
			MUL_RAW_SHI: begin
				ma = $signed({{(MOP_W-RAW_W){1'b0}}, raw_q});
				mb = MOP_W'($signed(stored_sens_q[STORE_W-1:20]));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		temp_full = sdiv_pow2(wide, 23) + ACC_W'(TEMP_REF);
		sens_full = $signed(ACC_W'({cal_q[REG_C1], 15'b0})) + sdiv_pow2(wide, 8);
		off_full  = $signed(ACC_W'({cal_q[REG_C2], 16'b0})) + sdiv_pow2(wide, 7);
		// squares are never negative, so plain shifts truncate correctly
		if (low_band) begin
			ti_full = ((wide <<< 1) + wide) >>> 33;
			offi    = ((wide <<< 1) + wide) >>> 1;
			sensi   = ((wide <<< 2) + wide) >>> 3;
		end else begin
			ti_full = wide >>> 36;
			offi    = wide >>> 4;
			sensi   = '0;
		end
		offv     = (wide <<< 3) - wide;
		sensv    = wide <<< 2;
		temp_out = ACC_W'(temp_q) - $signed({{(ACC_W-TI_W){1'b0}}, ti_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAL_NUM; i++) begin
				cal_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_C1:  cal_q[REG_C1] <= cfg_data;
				REG_C2:  cal_q[REG_C2] <= cfg_data;
				REG_C3:  cal_q[REG_C3] <= cfg_data;
				REG_C4:  cal_q[REG_C4] <= cfg_data;
				REG_C5:  cal_q[REG_C5] <= cfg_data;
				REG_C6:  cal_q[REG_C6] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_sens_q <= '0;
			stored_off_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ctl.go && (ctl.op == OP_STORE_T || ctl.op == OP_EMIT_P)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.go && ctl.op == OP_STORE_T) begin
				stored_sens_q <= sens_q;
				stored_off_q  <= off_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			raw_q <= raw;
		end
		if (ctl.go) begin
			prod_q <= ma * mb;
			unique case (ctl.op)
				OP_LOAD_DT: dt_q <= $signed({1'b0, raw_q}) - $signed({1'b0, cal_q[REG_C5], 8'b0});
				OP_TEMP:    temp_q <= temp_full[TEMP_W-1:0];
				OP_SENS:    sens_q <= sens_full[STORE_W-1:0];
				OP_OFF:     off_q <= off_full[STORE_W-1:0];
				OP_TI:      ti_q <= ti_full[TI_W-1:0];
				OP_BAND: begin
					off_q  <= off_q - offi[STORE_W-1:0];
					sens_q <= sens_q - sensi[STORE_W-1:0];
				end
				OP_VLOW: begin
					off_q  <= off_q - offv[STORE_W-1:0];
					sens_q <= sens_q - sensv[STORE_W-1:0];
				end
				OP_STORE_T: begin
					out_kind_q  <= KIND_TEMP;
					out_value_q <= sat32(temp_out);
				end
				OP_ACC_LO:  acc_q <= wide;
				OP_ACC_HI:  acc_q <= acc_q + (wide <<< 20);
				OP_DIV21:   acc_q <= sdiv_pow2(acc_q, 21);
				OP_SUB_OFF: acc_q <= acc_q - ACC_W'(stored_off_q);
				OP_EMIT_P: begin
					out_kind_q  <= KIND_PRES;
					out_value_q <= sat32(sdiv_pow2(acc_q, 13));
				end
				default: ;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign out_kind         = out_kind_q;
	assign out_value        = out_value_q;
	assign stat.vlow        = temp_q < VLOW_LIMIT;
	assign stat.out_blocked = out_valid_q & ~out_ready;

endmodule

### sv/baro_second_order_compensation.sv
// temperature request: runs the temperature program, with an extra correction step below -15 C
// pressure request: runs the pressure program; a new request is taken only after the result step
// the result timing comes from the microcode length; all products share one 26x26 multiplier
// a waiting result stalls the sequence only when it blocks the next result step
// reset clears calibration, stored offset and sensitivity, phase and output valid
// no clearing pass: the block is ready for a request as soon as reset is released
module baro_second_order_compensation #(
	parameter int unsigned PRESSURE_PER_TEMP = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	bsoc_in_if.sink           conversion,
	bsoc_out_if.source        result,
	bsoc_cfg_if.sink          cfg
);
	import bsoc_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;
	logic     seq_ready;
	logic     start;

	assign conversion.ready = seq_ready;
	assign start            = conversion.valid & seq_ready;
	assign cfg.ready        = 1'b1;

	bsoc_seq #(
		.PRESSURE_PER_TEMP(PRESSURE_PER_TEMP)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ready  (seq_ready),
		.ctl    (ctl)
	);

	bsoc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.raw       (conversion.raw_conversion),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_kind  (result.result_kind),
		.out_value (result.result_value),
		.stat      (stat)
	);

endmodule

### sv/bsoc_checker.sv
`include "assert_macros.svh"

module bsoc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               out_kind,
	input logic signed [bsoc_pkg::RES_W-1:0]  out_value
);
	// one request in flight: no second request right after one is taken
	`BSOC_ASSERT(a_one_in_flight, clk, arst_n, in_valid && in_ready |=> !in_ready, "request taken while busy")
	// a result never appears in the cycle right after its request
	`BSOC_ASSERT(a_min_latency, clk, arst_n, in_valid && in_ready && !out_valid |=> !out_valid, "result too early")
	`BSOC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`BSOC_ASSERT(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_value) && $stable(out_kind), "result changed while stalled")
	// reset empties the output register
	`BSOC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind baro_second_order_compensation bsoc_checker u_bsoc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (conversion.valid),
	.in_ready  (conversion.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.result_kind),
	.out_value (result.result_value)
);
